// ===== hdl/json_path_value_locator_assert.svh =====
// Assertion macros for the path value locator
`ifndef JSON_PATH_VALUE_LOCATOR_ASSERT_SVH
`define JSON_PATH_VALUE_LOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define JPVL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define JPVL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define JPVL_ASSERT(label, prop, msg)
`define JPVL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/jpvl_pkg.sv =====
package jpvl_pkg;

    localparam int PATH_BYTES  = 64;
    localparam int PATH_AW     = $clog2(PATH_BYTES);
    localparam int PATH_CW     = PATH_AW + 1;
    localparam int CNT_W       = 8;
    localparam int NAME_MAX    = 31;
    localparam int OFFSET_BITS = 24;
    localparam int DEPTH_BITS  = 8;
    localparam int INDEX_BITS  = 16;
    localparam int OUT_BITS    = 24;

    typedef enum logic [1:0] {
        OP_PATH   = 2'd0,
        OP_DOC    = 2'd1,
        OP_REPORT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_DOC_FAIL  = 2'd1,
        ST_PATH_FAIL = 2'd2,
        ST_UNUSED    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OC_PENDING   = 2'd0,
        OC_FOUND     = 2'd1,
        OC_DOC_FAIL  = 2'd2,
        OC_PATH_FAIL = 2'd3
    } t_outcome;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_LBRK   = 8'h5b;
    localparam logic [7:0] CH_RBRK   = 8'h5d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_E   = 8'h45;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
    endfunction

    function automatic logic is_ws_ext(input logic [7:0] b);
        return is_ws(b) || (b == 8'h0b) || (b == 8'h0c);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_bare(input logic [7:0] b);
        return ((b >= CH_LOW_A) && (b <= CH_LOW_U)) || ((b >= CH_MINUS) && (b <= CH_NINE))
            || (b == CH_UP_E);
    endfunction

endpackage

// ===== hdl/json_path_value_locator.sv =====
// Path value locator: finds one value in a JSON document by a dotted path.
// Input channel (i_s_*): one word per cycle at most; tuser carries the op
// (path byte, document byte, end of document), tdata the raw byte.
// Output channel (o_m_*): one word per end-of-document op, carrying the
// status in tuser and the value's offset and length in tdata.
// A document byte passes through the walk and commit states, and through a key
// state as well while a key is compared (one read of the path memory); the byte
// that ends a skipped bare value is walked again. The first document byte, or an
// end of document with no document bytes, first scans the path memory: the syntax
// check reads each path byte, reading again the byte that ends each name at a dot
// or bracket, then the first segment is read (leading dots and closing delimiter
// included). Each later segment is scanned the same way as it is reached.
// The path sits in a 64 x 8 synchronous memory with one registered read port.
// Reset (synchronous, active low) clears the walk and the path length; no
// clearing pass runs. The report also returns the block to that state. While
// the receiver stalls, the result is held in the output register and input
// words are still taken, until a second report waits.
`include "json_path_value_locator_assert.svh"

module json_path_value_locator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [23:0] value_start, [47:24] value_length
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int AW = jpvl_pkg::PATH_AW;
    localparam int CW = jpvl_pkg::PATH_CW;
    localparam int OW = jpvl_pkg::OFFSET_BITS;
    localparam int DW = jpvl_pkg::DEPTH_BITS;
    localparam int IW = jpvl_pkg::INDEX_BITS;
    localparam int KW = jpvl_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PC_RD, S_PC_USE, S_BS_RD, S_BS_USE, S_WALK, S_WALK_KEY, S_COMMIT, S_REPORT
    } t_state;

    typedef enum logic [3:0] {
        W_IDLE, W_OBJ_OPEN, W_ARR_OPEN, W_KEY_OPEN, W_KEY_MATCH, W_KEY_REST, W_COLON_SKIP,
        W_COLON_HIT, W_VAL_WS, W_VAL_CONT, W_VAL_CSTR, W_VAL_STR, W_VAL_BARE, W_COMMA_OBJ,
        W_COMMA_ARR, W_DONE
    } t_walk;

    typedef enum logic [1:0] {T_OBJ, T_ARR, T_GET, T_NONE} t_target;
    typedef enum logic [1:0] {PC_SEG, PC_BRK, PC_NAME, PC_NONE} t_pc_mode;
    typedef enum logic [2:0] {BS_DOTS, BS_NAME, BS_IDX_WS, BS_IDX_DIG, BS_IDX_REST} t_bs_mode;

    logic [7:0] mem [jpvl_pkg::PATH_BYTES];
    logic [7:0] r_rdata;
    logic       w_we;
    logic [AW-1:0] w_waddr, w_raddr;

    t_state   r_state, n_state;
    t_walk    r_walk, n_walk;
    t_target  r_target, n_target;
    jpvl_pkg::t_outcome r_outcome, n_outcome;
    t_pc_mode r_pc_mode, n_pc_mode;
    t_bs_mode r_bs_mode, n_bs_mode;
    logic          r_pc_ret, n_pc_ret;
    logic          r_bs_ret, n_bs_ret;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_len, n_len, r_cursor, n_cursor, r_seg_end, n_seg_end;
    logic [CW-1:0] r_match, n_match, r_pos, n_pos;
    logic [KW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_idx, n_idx, r_skip, n_skip;
    logic [OW-1:0] r_offset, n_offset, r_found_start, n_found_start;
    logic [OW-1:0] r_found_len, n_found_len;
    logic [DW-1:0] r_nest, n_nest;
    logic [7:0]    r_open, n_open, r_prior, n_prior, r_byte, n_byte;
    logic [1:0]    r_op, n_op;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    logic [jpvl_pkg::OUT_BITS-1:0] r_out_start, n_out_start, r_out_len, n_out_len;

    logic [7:0]    w_d;
    logic [IW+3:0] w_idx_next;
    logic          w_qend;

    assign w_d        = r_rdata - jpvl_pkg::CH_ZERO;
    assign w_idx_next = {4'b0, r_idx} * (IW + 4)'(10) + (IW + 4)'(w_d[3:0]);
    assign w_qend     = (r_byte == jpvl_pkg::CH_QUOTE) && (r_prior != jpvl_pkg::CH_BSLASH);

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= i_s_tdata;
        r_rdata <= mem[w_raddr];
    end

    always_comb begin
        logic          v_fail, v_finish, v_bs, v_reread, v_key, v_pc_end, v_pc_ok;
        logic          v_bs_idx;
        logic [OW-1:0] v_end;
        logic [IW-1:0] v_skip;
        n_state = r_state;         n_walk = r_walk;           n_target = r_target;
        n_outcome = r_outcome;     n_pc_mode = r_pc_mode;     n_bs_mode = r_bs_mode;
        n_pc_ret = r_pc_ret;       n_bs_ret = r_bs_ret;       n_neg = r_neg;
        n_len = r_len;             n_cursor = r_cursor;       n_seg_end = r_seg_end;
        n_match = r_match;         n_pos = r_pos;             n_cnt = r_cnt;
        n_idx = r_idx;             n_skip = r_skip;           n_offset = r_offset;
        n_found_start = r_found_start;                        n_found_len = r_found_len;
        n_nest = r_nest;           n_open = r_open;           n_prior = r_prior;
        n_byte = r_byte;           n_op = r_op;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_status = r_out_status; n_out_start = r_out_start; n_out_len = r_out_len;
        w_we = 1'b0;
        w_waddr = r_len[AW-1:0];
        w_raddr = r_pos[AW-1:0];
        v_fail = 1'b0; v_finish = 1'b0; v_bs = 1'b0; v_reread = 1'b0; v_key = 1'b0;
        v_pc_end = 1'b0; v_pc_ok = 1'b0; v_bs_idx = 1'b0;
        v_end = r_offset;
        v_skip = r_skip;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_byte = i_s_tdata;
                    n_op = i_s_tuser;
                    case (jpvl_pkg::t_op'(i_s_tuser))
                        jpvl_pkg::OP_PATH: begin
                            if (r_walk == W_IDLE && r_outcome == jpvl_pkg::OC_PENDING) begin
                                if (r_len < CW'(jpvl_pkg::PATH_BYTES)) begin
                                    w_we = 1'b1;
                                    n_len = r_len + CW'(1);
                                end else begin
                                    n_outcome = jpvl_pkg::OC_PATH_FAIL;
                                end
                            end
                        end
                        jpvl_pkg::OP_DOC: begin
                            if (r_outcome == jpvl_pkg::OC_PENDING) begin
                                if (&r_offset) begin
                                    n_outcome = jpvl_pkg::OC_DOC_FAIL;
                                    n_walk = W_DONE;
                                end else if (r_walk == W_IDLE) begin
                                    n_pos = '0; n_pc_mode = PC_SEG; n_pc_ret = 1'b0;
                                    n_state = S_PC_RD;
                                end else begin
                                    n_state = S_WALK;
                                end
                            end
                        end
                        jpvl_pkg::OP_REPORT: begin
                            if (r_outcome == jpvl_pkg::OC_PENDING && r_walk == W_IDLE) begin
                                n_pos = '0; n_pc_mode = PC_SEG; n_pc_ret = 1'b1;
                                n_state = S_PC_RD;
                            end else begin
                                if (r_outcome == jpvl_pkg::OC_PENDING) begin
                                    if (r_walk == W_VAL_BARE && r_target == T_GET) begin
                                        n_found_len = r_offset - r_found_start;
                                        n_outcome = jpvl_pkg::OC_FOUND;
                                    end else begin
                                        n_outcome = jpvl_pkg::OC_DOC_FAIL;
                                    end
                                end
                                n_state = S_REPORT;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // path syntax check
            S_PC_RD: begin
                if (r_pos >= r_len) begin
                    v_pc_end = 1'b1;
                    v_pc_ok = (r_pc_mode != PC_BRK);
                end else begin
                    n_state = S_PC_USE;
                end
            end
            S_PC_USE: begin
                n_state = S_PC_RD;
                case (r_pc_mode)
                    PC_SEG: begin
                        n_pos = r_pos + CW'(1);
                        if (r_rdata == jpvl_pkg::CH_LBRK) begin
                            n_pc_mode = PC_BRK; n_cnt = '0;
                        end else if (r_rdata != jpvl_pkg::CH_DOT) begin
                            n_pc_mode = PC_NAME; n_cnt = KW'(1);
                        end
                    end
                    PC_BRK: begin
                        n_pos = r_pos + CW'(1);
                        if (r_rdata == jpvl_pkg::CH_RBRK) begin
                            n_pc_mode = PC_SEG;
                        end else if (r_cnt >= KW'(jpvl_pkg::NAME_MAX)) begin
                            v_pc_end = 1'b1;
                        end else begin
                            n_cnt = r_cnt + KW'(1);
                        end
                    end
                    default: begin
                        if (r_rdata == jpvl_pkg::CH_LBRK || r_rdata == jpvl_pkg::CH_DOT) begin
                            n_pc_mode = PC_SEG;
                        end else if (r_cnt >= KW'(jpvl_pkg::NAME_MAX)) begin
                            v_pc_end = 1'b1;
                        end else begin
                            n_cnt = r_cnt + KW'(1);
                            n_pos = r_pos + CW'(1);
                        end
                    end
                endcase
            end

            // segment scan
            S_BS_RD: begin
                if (r_pos >= r_len) begin
                    case (r_bs_mode)
                        BS_DOTS: begin
                            n_target = T_GET; n_walk = W_VAL_WS;
                        end
                        BS_NAME: begin
                            n_seg_end = r_pos; n_walk = W_OBJ_OPEN;
                        end
                        default: begin
                            n_skip = r_neg ? '0 : r_idx;
                            n_seg_end = r_pos; n_walk = W_ARR_OPEN;
                        end
                    endcase
                    n_state = r_bs_ret ? S_WALK : S_COMMIT;
                end else begin
                    n_state = S_BS_USE;
                end
            end
            S_BS_USE: begin
                n_state = S_BS_RD;
                n_pos = r_pos + CW'(1);
                case (r_bs_mode)
                    BS_DOTS: begin
                        if (r_rdata == jpvl_pkg::CH_LBRK) begin
                            n_bs_mode = BS_IDX_WS; n_neg = 1'b0; n_idx = '0;
                        end else if (r_rdata != jpvl_pkg::CH_DOT) begin
                            n_bs_mode = BS_NAME; n_cursor = r_pos;
                        end
                    end
                    BS_NAME: begin
                        if (r_rdata == jpvl_pkg::CH_LBRK || r_rdata == jpvl_pkg::CH_DOT) begin
                            n_seg_end = r_pos; n_walk = W_OBJ_OPEN;
                            n_state = r_bs_ret ? S_WALK : S_COMMIT;
                        end
                    end
                    default: v_bs_idx = 1'b1;
                endcase
                if (v_bs_idx) begin
                    if (r_rdata == jpvl_pkg::CH_RBRK) begin
                        n_skip = r_neg ? '0 : r_idx;
                        n_seg_end = r_pos + CW'(1); n_walk = W_ARR_OPEN;
                        n_state = r_bs_ret ? S_WALK : S_COMMIT;
                    end else if (r_bs_mode == BS_IDX_WS) begin
                        if (jpvl_pkg::is_ws_ext(r_rdata)) begin
                            n_bs_mode = BS_IDX_WS;
                        end else if (r_rdata == jpvl_pkg::CH_MINUS ||
                                     r_rdata == jpvl_pkg::CH_PLUS) begin
                            n_neg = (r_rdata == jpvl_pkg::CH_MINUS);
                            n_bs_mode = BS_IDX_DIG;
                        end else if (jpvl_pkg::is_digit(r_rdata)) begin
                            n_idx = IW'(w_d[3:0]);
                            n_bs_mode = BS_IDX_DIG;
                        end else begin
                            n_bs_mode = BS_IDX_REST;
                        end
                    end else if (r_bs_mode == BS_IDX_DIG) begin
                        if (jpvl_pkg::is_digit(r_rdata)) begin
                            n_idx = (w_idx_next > (IW + 4)'({IW{1'b1}})) ? {IW{1'b1}}
                                                                          : w_idx_next[IW-1:0];
                        end else begin
                            n_bs_mode = BS_IDX_REST;
                        end
                    end
                end
            end

            S_WALK: begin
                case (r_walk)
                    W_OBJ_OPEN: if (!jpvl_pkg::is_ws(r_byte)) begin
                        if (r_byte == jpvl_pkg::CH_LBRACE) n_walk = W_KEY_OPEN;
                        else v_fail = 1'b1;
                    end
                    W_ARR_OPEN: if (!jpvl_pkg::is_ws(r_byte)) begin
                        if (r_byte != jpvl_pkg::CH_LBRK) v_fail = 1'b1;
                        else if (r_skip == '0) v_bs = 1'b1;
                        else begin n_target = T_ARR; n_walk = W_VAL_WS; end
                    end
                    W_KEY_OPEN: if (!jpvl_pkg::is_ws(r_byte)) begin
                        if (r_byte == jpvl_pkg::CH_QUOTE) begin
                            n_match = r_cursor; n_walk = W_KEY_MATCH;
                        end else v_fail = 1'b1;
                    end
                    W_KEY_MATCH: begin
                        if (r_match < r_seg_end) v_key = 1'b1;
                        else n_walk = (r_byte == jpvl_pkg::CH_QUOTE) ? W_COLON_HIT : W_KEY_REST;
                    end
                    W_KEY_REST: if (w_qend) n_walk = W_COLON_SKIP;
                    W_COLON_SKIP: if (!jpvl_pkg::is_ws(r_byte)) begin
                        if (r_byte == jpvl_pkg::CH_COLON) begin
                            n_target = T_OBJ; n_walk = W_VAL_WS;
                        end else v_fail = 1'b1;
                    end
                    W_COLON_HIT: if (!jpvl_pkg::is_ws(r_byte)) begin
                        if (r_byte == jpvl_pkg::CH_COLON) v_bs = 1'b1;
                        else v_fail = 1'b1;
                    end
                    W_VAL_WS: if (!jpvl_pkg::is_ws(r_byte)) begin
                        if (r_target == T_GET) n_found_start = r_offset;
                        if (r_byte == jpvl_pkg::CH_LBRACE || r_byte == jpvl_pkg::CH_LBRK) begin
                            n_open = r_byte; n_nest = '0; n_walk = W_VAL_CONT;
                        end else if (r_byte == jpvl_pkg::CH_QUOTE) n_walk = W_VAL_STR;
                        else n_walk = W_VAL_BARE;
                    end
                    W_VAL_CONT: begin
                        if (r_byte == jpvl_pkg::CH_QUOTE) n_walk = W_VAL_CSTR;
                        else if (r_byte == r_open + 8'd2) begin
                            if (r_nest == '0) begin
                                v_finish = 1'b1; v_end = r_offset + OW'(1);
                            end else n_nest = r_nest - DW'(1);
                        end else if (r_byte == r_open) begin
                            if (&r_nest) v_fail = 1'b1;
                            else n_nest = r_nest + DW'(1);
                        end
                    end
                    W_VAL_CSTR: if (w_qend) n_walk = W_VAL_CONT;
                    W_VAL_STR: if (w_qend) begin
                        v_finish = 1'b1; v_end = r_offset + OW'(1);
                    end
                    W_VAL_BARE: if (!jpvl_pkg::is_bare(r_byte)) begin
                        // unless this is the value sought, the terminating byte is read again as the next token
                        v_finish = 1'b1; v_reread = 1'b1;
                    end
                    W_COMMA_OBJ: if (!jpvl_pkg::is_ws(r_byte)) begin
                        if (r_byte == jpvl_pkg::CH_COMMA) n_walk = W_KEY_OPEN;
                        else v_fail = 1'b1;
                    end
                    W_COMMA_ARR: if (!jpvl_pkg::is_ws(r_byte)) begin
                        if (r_byte != jpvl_pkg::CH_COMMA) v_fail = 1'b1;
                        else begin
                            v_skip = (r_skip != '0) ? r_skip - IW'(1) : r_skip;
                            n_skip = v_skip;
                            if (v_skip == '0) v_bs = 1'b1;
                            else begin n_target = T_ARR; n_walk = W_VAL_WS; end
                        end
                    end
                    default: ;
                endcase
                if (v_finish) begin
                    if (r_target == T_GET) begin
                        n_found_len = v_end - r_found_start;
                        n_outcome = jpvl_pkg::OC_FOUND;
                        n_walk = W_DONE;
                        v_reread = 1'b0;
                    end else begin
                        n_walk = (r_target == T_OBJ) ? W_COMMA_OBJ : W_COMMA_ARR;
                    end
                end
                if (v_fail) begin
                    n_outcome = jpvl_pkg::OC_DOC_FAIL;
                    n_walk = W_DONE;
                end
                if (v_key) begin
                    w_raddr = r_match[AW-1:0];
                    n_state = S_WALK_KEY;
                end else if (v_bs) begin
                    n_pos = r_seg_end; n_bs_mode = BS_DOTS; n_bs_ret = 1'b0;
                    n_state = S_BS_RD;
                end else if (!v_reread) begin
                    n_state = S_COMMIT;
                end
            end

            S_WALK_KEY: begin
                if (r_byte == r_rdata) n_match = r_match + CW'(1);
                else if (w_qend) n_walk = W_COLON_SKIP;
                else n_walk = W_KEY_REST;
                n_state = S_COMMIT;
            end

            S_COMMIT: begin
                n_prior = r_byte;
                n_offset = r_offset + OW'(1);
                n_state = S_IDLE;
            end

            S_REPORT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    if (r_outcome == jpvl_pkg::OC_FOUND) begin
                        n_out_status = jpvl_pkg::ST_FOUND;
                        n_out_start = r_found_start;
                        n_out_len = r_found_len;
                    end else begin
                        n_out_status = (r_outcome == jpvl_pkg::OC_PATH_FAIL)
                                     ? jpvl_pkg::ST_PATH_FAIL : jpvl_pkg::ST_DOC_FAIL;
                        n_out_start = '0;
                        n_out_len = '0;
                    end
                    // back to the state after reset
                    n_len = '0; n_cursor = '0; n_seg_end = '0; n_match = '0;
                    n_walk = W_IDLE; n_target = T_OBJ; n_outcome = jpvl_pkg::OC_PENDING;
                    n_offset = '0; n_found_start = '0; n_found_len = '0;
                    n_skip = '0; n_nest = '0; n_open = '0; n_prior = '0;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (v_pc_end) begin
            if (r_pc_ret) begin
                n_outcome = v_pc_ok ? jpvl_pkg::OC_DOC_FAIL : jpvl_pkg::OC_PATH_FAIL;
                n_state = S_REPORT;
            end else if (v_pc_ok) begin
                n_seg_end = '0; n_pos = '0; n_bs_mode = BS_DOTS; n_bs_ret = 1'b1;
                n_state = S_BS_RD;
            end else begin
                n_outcome = jpvl_pkg::OC_PATH_FAIL;
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;       r_walk <= W_IDLE;        r_target <= T_OBJ;
            r_outcome <= jpvl_pkg::OC_PENDING;
            r_pc_mode <= PC_SEG;     r_bs_mode <= BS_DOTS;
            r_pc_ret <= 1'b0;        r_bs_ret <= 1'b0;        r_neg <= 1'b0;
            r_len <= '0;             r_cursor <= '0;          r_seg_end <= '0;
            r_match <= '0;           r_pos <= '0;             r_cnt <= '0;
            r_idx <= '0;             r_skip <= '0;            r_offset <= '0;
            r_found_start <= '0;     r_found_len <= '0;       r_nest <= '0;
            r_open <= '0;            r_prior <= '0;           r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;      r_walk <= n_walk;        r_target <= n_target;
            r_outcome <= n_outcome;
            r_pc_mode <= n_pc_mode;  r_bs_mode <= n_bs_mode;
            r_pc_ret <= n_pc_ret;    r_bs_ret <= n_bs_ret;    r_neg <= n_neg;
            r_len <= n_len;          r_cursor <= n_cursor;    r_seg_end <= n_seg_end;
            r_match <= n_match;      r_pos <= n_pos;          r_cnt <= n_cnt;
            r_idx <= n_idx;          r_skip <= n_skip;        r_offset <= n_offset;
            r_found_start <= n_found_start; r_found_len <= n_found_len; r_nest <= n_nest;
            r_open <= n_open;        r_prior <= n_prior;      r_out_valid <= n_out_valid;
        end
        r_byte <= n_byte;
        r_op <= n_op;
        r_out_status <= n_out_status;
        r_out_start <= n_out_start;
        r_out_len <= n_out_len;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_len, r_out_start};
    assign o_m_tuser  = r_out_status;

    `JPVL_ASSERT(a_len_bound, r_len <= CW'(jpvl_pkg::PATH_BYTES), "path length overran")
    `JPVL_ASSERT(a_done_decided, r_walk == W_DONE |-> r_outcome != jpvl_pkg::OC_PENDING, "no outcome")
    `JPVL_ASSERT(a_fail_zero, o_m_tvalid && o_m_tuser != jpvl_pkg::ST_FOUND |-> o_m_tdata == '0, "data")
    `JPVL_ASSERT(a_match_bound, r_walk == W_KEY_MATCH |-> r_match <= r_seg_end, "key compare overran")
    `JPVL_ASSERT(a_walk_op, r_state == S_WALK |-> r_op == jpvl_pkg::OP_DOC, "walk started by wrong op")

endmodule
